[rtl/lsps_pkg.sv]
// Shared types and constants for the line-sensor PD steering unit.
// Used by lsps_cfg, lsps_div and line_sensor_pd_steering_unit; depends on nothing.
package lsps_pkg;

    // Scan geometry
    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SENSOR_IN_W      = 8;
    localparam int MAX_LINES        = 4;
    localparam int LINE_W           = 2;
    localparam int LINE_CNT_W       = 3;
    localparam int POS_W            = 8;

    // Arithmetic constants
    localparam int CENTRE      = 35;
    localparam int POS_SCALE   = 10;
    localparam int GAIN_DIV    = 1000;
    localparam int SPEED_SCHED = 40;
    localparam int KP_LOW      = 2;
    localparam int KD_LOW      = 4;
    localparam int GAIN_W      = 9;
    localparam int SLOW_W      = 9;
    localparam int OFS_W       = 7;
    localparam int DRIVE_W     = 16;

    // Shared divider: dividend and divisor widths
    localparam int DIV_W = 18;
    localparam int DVS_W = 10;

    // Constant divisions by reciprocal multiply: q = (x * RCP) >> SH, exact over the
    // operand ranges used (gain products below 2^18, slow-down products below 2^14).
    localparam int               RCP_GAIN_W    = 19;
    localparam logic [18:0]      RCP_GAIN      = 19'd268436;   // ceil(2^28 / 1000)
    localparam int               RCP_GAIN_SH   = 28;
    localparam int               RCP_CENTRE_W  = 15;
    localparam logic [14:0]      RCP_CENTRE    = 15'd29960;    // ceil(2^20 / 35)
    localparam int               RCP_CENTRE_SH = 20;

    // Line choice modes
    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_SELECT   = 2'd1;
    localparam logic [1:0] MODE_LEFTMOST = 2'd2;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SELECT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_P_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_D_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_D_PERIOD     = 3'd6;

    typedef struct packed {
        logic [1:0]  offset_mode;
        logic [1:0]  line_select;
        logic [3:0]  width_limit;
        logic [7:0]  base_speed;
        logic [9:0]  speed_p_gain;
        logic [9:0]  speed_d_gain;
        logic [15:0] d_update_period;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/lsps_cfg.sv]
// Configuration register file of the steering unit.
// Depends on lsps_pkg for the register map and the t_cfg struct.
module lsps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0] i_data,
    output lsps_pkg::t_cfg                 o_cfg
);
    import lsps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_mode     <= MODE_LEFTMOST;
            r_cfg.line_select     <= 2'd0;
            r_cfg.width_limit     <= 4'd2;
            r_cfg.base_speed      <= 8'd70;
            r_cfg.speed_p_gain    <= 10'd40;
            r_cfg.speed_d_gain    <= 10'd80;
            r_cfg.d_update_period <= 16'd500;
        end else if (i_valid) begin
            case (i_index)
                REG_OFFSET_MODE:  r_cfg.offset_mode     <= i_data[1:0];
                REG_LINE_SELECT:  r_cfg.line_select     <= i_data[1:0];
                REG_WIDTH_LIMIT:  r_cfg.width_limit     <= i_data[3:0];
                REG_BASE_SPEED:   r_cfg.base_speed      <= i_data[7:0];
                REG_SPEED_P_GAIN: r_cfg.speed_p_gain    <= i_data[9:0];
                REG_SPEED_D_GAIN: r_cfg.speed_d_gain    <= i_data[9:0];
                REG_D_PERIOD:     r_cfg.d_update_period <= i_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/lsps_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on lsps_pkg for widths and the request/response structs.
module lsps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsps_pkg::t_div_req i_req,
    output lsps_pkg::t_div_rsp o_rsp
);
    import lsps_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_quo;

    logic [DVS_W:0]   n_trial;
    logic [DVS_W-1:0] n_rem;
    logic             n_bit;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(n_trial - {1'b0, r_dvs});
            n_bit = 1'b1;
        end else begin
            n_rem = n_trial[DVS_W-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIV_W-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[rtl/line_sensor_pd_steering_unit.sv]
// Line-sensor PD steering unit: run scan, line choice and speed-scheduled PD drive.
// The scan visits each sensor in turn and then one step past the last, and each line's
// position is then computed on the shared 18-bit divider, one bit per cycle.
// Throughput: one request at a time, taken the cycle after the result enters the output
// register. Reset (synchronous, active low) restores defaults and clears PD state.
module line_sensor_pd_steering_unit #(
    parameter int SENSOR_COUNT = lsps_pkg::SENSOR_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sensor_bits[7:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    // left_drive[15:0], right_drive[31:16], line_offset[38:32], lines_seen[41:39]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [47:0]                     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsps_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_COUNT + 1);
    localparam int LEN_W = $clog2(SENSOR_COUNT + 1);
    localparam int SUM_W = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_POS_GO, S_POS_WAIT, S_KP_GO, S_KP_WAIT, S_KD_GO, S_KD_WAIT,
        S_SELECT, S_DERIV, S_SLOW_GO, S_SLOW_WAIT, S_PD, S_OUT
    } t_state;

    t_cfg     cfg;
    t_div_req n_div_req;
    t_div_rsp div_rsp;

    lsps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lsps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (div_rsp)
    );

    t_state                  r_state;
    logic [SENSOR_IN_W-1:0]  r_bits;
    logic [IDX_W-1:0]        r_idx;
    logic [LEN_W-1:0]        r_run_len;
    logic [SUM_W-1:0]        r_run_sum;
    logic [LINE_CNT_W-1:0]   r_n;
    logic [LINE_CNT_W-1:0]   r_k;
    logic [SUM_W-1:0]        r_sum [MAX_LINES];
    logic [LEN_W-1:0]        r_len [MAX_LINES];
    logic [POS_W-1:0]        r_pos [MAX_LINES];
    logic [DIV_W-1:0]        r_prod;
    logic [GAIN_W-1:0]       r_kp;
    logic [GAIN_W-1:0]       r_kd;
    logic signed [OFS_W-1:0] r_offset;
    logic signed [OFS_W-1:0] r_prev;
    logic [16:0]             r_period;
    logic signed [15:0]      r_deriv;
    logic [SLOW_W-1:0]       r_slow;
    logic signed [17:0]      r_pd;
    logic                    r_out_valid;
    logic [47:0]             r_out_data;

    logic                    n_on;
    logic                    n_slow_speed;
    logic signed [8:0]       n_rel [MAX_LINES];
    logic [8:0]              n_abs;
    logic [7:0]              n_dist;
    logic [7:0]              n_best;
    logic [LINE_W-1:0]       n_bidx;
    logic signed [8:0]       n_sel;
    logic signed [OFS_W-1:0] n_offset;
    logic signed [7:0]       n_diff;
    logic signed [17:0]      n_dprod;
    logic signed [15:0]      n_deriv;
    logic [OFS_W-1:0]        n_abs_off;
    logic signed [17:0]      n_pd;
    logic signed [19:0]      n_left_w;
    logic signed [19:0]      n_right_w;
    logic [DRIVE_W-1:0]      n_left;
    logic [DRIVE_W-1:0]      n_right;
    logic [DIV_W+RCP_GAIN_W-1:0]   n_gain_prod;
    logic [DIV_W+RCP_CENTRE_W-1:0] n_slow_prod;
    logic [GAIN_W-1:0]       n_gain_q;
    logic [SLOW_W-1:0]       n_slow_q;

    // Scan: bits shift in from the top as zeros, so sensors past the input read as dark.
    assign n_on         = r_bits[0] && (r_idx != IDX_W'(SENSOR_COUNT));
    assign n_slow_speed = (cfg.base_speed < 8'(SPEED_SCHED));

    // Divide the held product by 1000 or by the centre through a reciprocal multiply.
    assign n_gain_prod = {{RCP_GAIN_W{1'b0}}, r_prod} * {{DIV_W{1'b0}}, RCP_GAIN};
    assign n_slow_prod = {{RCP_CENTRE_W{1'b0}}, r_prod} * {{DIV_W{1'b0}}, RCP_CENTRE};
    assign n_gain_q    = n_gain_prod[RCP_GAIN_SH +: GAIN_W];
    assign n_slow_q    = n_slow_prod[RCP_CENTRE_SH +: SLOW_W];

    // Line choice
    always_comb begin
        n_best = 8'hFF;
        n_bidx = '0;
        n_abs  = '0;
        n_dist = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            n_rel[i] = $signed({1'b0, r_pos[i]}) - $signed(9'(CENTRE));
        end
        // Strict compare keeps the lowest-numbered line on a tie.
        for (int i = 0; i < MAX_LINES; i++) begin
            n_abs  = n_rel[i][8] ? 9'(-n_rel[i]) : 9'(n_rel[i]);
            n_dist = n_abs[7:0];
            if ((LINE_CNT_W'(i) < r_n) && (n_dist < n_best)) begin
                n_best = n_dist;
                n_bidx = LINE_W'(i);
            end
        end
        priority if (r_n == '0) begin
            n_sel = '0;
        end else if (cfg.offset_mode == MODE_LEFTMOST) begin
            n_sel = (int'(r_len[0]) > int'(cfg.width_limit)) ? 9'sd0 : n_rel[0];
        end else if ((cfg.offset_mode == MODE_SELECT) &&
                     ({1'b0, cfg.line_select} < r_n)) begin
            n_sel = n_rel[cfg.line_select];
        end else begin
            n_sel = n_rel[n_bidx];
        end
        if (n_sel > 9'sd63) begin
            n_offset = 7'sd63;
        end else if (n_sel < -9'sd64) begin
            n_offset = -7'sd64;
        end else begin
            n_offset = n_sel[OFS_W-1:0];
        end
    end

    // Derivative, slow-down and drives
    always_comb begin
        n_diff  = $signed({r_offset[OFS_W-1], r_offset}) - $signed({r_prev[OFS_W-1], r_prev});
        n_dprod = $signed({1'b0, r_kd}) * n_diff;
        if (n_dprod > 18'sd32767) begin
            n_deriv = 16'sh7FFF;
        end else if (n_dprod < -18'sd32768) begin
            n_deriv = -16'sh8000;
        end else begin
            n_deriv = n_dprod[15:0];
        end
        n_abs_off = r_offset[OFS_W-1] ? OFS_W'(-r_offset) : OFS_W'(r_offset);
        n_pd      = $signed({1'b0, r_kp}) * r_offset + r_deriv;
        n_left_w  = $signed({12'd0, cfg.base_speed}) - r_pd - $signed({11'd0, r_slow});
        n_right_w = $signed({12'd0, cfg.base_speed}) + r_pd - $signed({11'd0, r_slow});
        if (n_left_w > 20'sd32767) begin
            n_left = 16'h7FFF;
        end else if (n_left_w < -20'sd32768) begin
            n_left = 16'h8000;
        end else begin
            n_left = n_left_w[15:0];
        end
        if (n_right_w > 20'sd32767) begin
            n_right = 16'h7FFF;
        end else if (n_right_w < -20'sd32768) begin
            n_right = 16'h8000;
        end else begin
            n_right = n_right_w[15:0];
        end
    end

    // Divider requests
    always_comb begin
        n_div_req.start    = 1'b0;
        n_div_req.dividend = '0;
        n_div_req.divisor  = DVS_W'(1);
        unique case (r_state)
            S_POS_GO: begin
                n_div_req.start    = (r_k != r_n);
                n_div_req.dividend = DIV_W'(r_sum[r_k[LINE_W-1:0]]) * DIV_W'(POS_SCALE);
                n_div_req.divisor  = DVS_W'(r_len[r_k[LINE_W-1:0]]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_period    <= '0;
            r_deriv     <= '0;
            r_n         <= '0;
            r_k         <= '0;
        end else begin
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_bits    <= s_axis_tdata;
                        r_idx     <= '0;
                        r_run_len <= '0;
                        r_run_sum <= '0;
                        r_n       <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_bits <= r_bits >> 1;
                    r_idx  <= r_idx + 1'b1;
                    if (n_on) begin
                        r_run_len <= r_run_len + 1'b1;
                        r_run_sum <= r_run_sum + SUM_W'(r_idx);
                    end else if (r_run_len != '0) begin
                        // Keep the first four runs, drop the rest.
                        if (r_n < LINE_CNT_W'(MAX_LINES)) begin
                            r_sum[r_n[LINE_W-1:0]] <= r_run_sum;
                            r_len[r_n[LINE_W-1:0]] <= r_run_len;
                            r_n <= r_n + 1'b1;
                        end
                        r_run_len <= '0;
                        r_run_sum <= '0;
                    end
                    if (r_idx == IDX_W'(SENSOR_COUNT)) begin
                        r_k     <= '0;
                        r_state <= S_POS_GO;
                    end
                end
                S_POS_GO: begin
                    r_state <= (r_k == r_n) ? S_KP_GO : S_POS_WAIT;
                end
                S_POS_WAIT: begin
                    if (div_rsp.done) begin
                        r_pos[r_k[LINE_W-1:0]] <= div_rsp.quotient[POS_W-1:0];
                        r_k     <= r_k + 1'b1;
                        r_state <= S_POS_GO;
                    end
                end
                S_KP_GO: begin
                    r_prod  <= DIV_W'(cfg.base_speed) * DIV_W'(cfg.speed_p_gain);
                    r_state <= S_KP_WAIT;
                end
                S_KP_WAIT: begin
                    r_kp    <= n_slow_speed ? GAIN_W'(KP_LOW) : n_gain_q;
                    r_state <= S_KD_GO;
                end
                S_KD_GO: begin
                    r_prod  <= DIV_W'(cfg.base_speed) * DIV_W'(cfg.speed_d_gain);
                    r_state <= S_KD_WAIT;
                end
                S_KD_WAIT: begin
                    r_kd    <= n_slow_speed ? GAIN_W'(KD_LOW) : n_gain_q;
                    r_state <= S_SELECT;
                end
                S_SELECT: begin
                    r_offset <= n_offset;
                    r_state  <= S_DERIV;
                end
                S_DERIV: begin
                    // Refresh the derivative term once the period count has passed.
                    if (r_period > {1'b0, cfg.d_update_period}) begin
                        r_period <= '0;
                        r_deriv  <= n_deriv;
                        r_prev   <= r_offset;
                    end else begin
                        r_period <= r_period + 1'b1;
                    end
                    r_state <= S_SLOW_GO;
                end
                S_SLOW_GO: begin
                    r_prod  <= DIV_W'(n_abs_off) * DIV_W'(cfg.base_speed);
                    r_state <= S_SLOW_WAIT;
                end
                S_SLOW_WAIT: begin
                    r_slow  <= n_slow_q;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_pd    <= n_pd;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {6'd0, r_n, r_offset, n_right, n_left};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

endmodule
